// File: hw/rtl/sof_pkg.sv
package sof_pkg;

  localparam int SIDE        = 32;
  localparam int POS_W       = $clog2(SIDE);
  localparam int CHAIN_LEN   = 2 * SIDE;

  localparam int PIX_W       = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;

  // Must stay a power of two so the queue pointers wrap on their own.
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 3);

  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTLINE     = 1'd1;

  localparam logic [PIX_W-1:0] TRANSPARENT_RESET = 3'd0;
  localparam logic [PIX_W-1:0] OUTLINE_RESET     = 3'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // Rows top, middle, bottom by first index; columns left, center, right by second.
  typedef pix_t [2:0][2:0] window_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } mask_t;

  typedef struct packed {
    pix_t out_index;
    logic run_last;
    logic frame_end;
  } result_t;

endpackage

// File: hw/rtl/sof_if.sv
interface sof_pixel_if;
  logic          valid;
  logic          ready;
  sof_pkg::pix_t pixel_index;
  logic          frame_start;

  modport source (output valid, output pixel_index, output frame_start, input ready);
  modport sink (input valid, input pixel_index, input frame_start, output ready);
endinterface

interface sof_result_if;
  logic          valid;
  logic          ready;
  sof_pkg::pix_t out_index;
  logic          run_last;
  logic          frame_end;

  modport source (output valid, output out_index, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input out_index, input run_last, input frame_end,
                output ready);
endinterface

// File: hw/rtl/sof_cell.sv
module sof_cell (
  input  logic          clk,
  input  logic          shift,
  input  sof_pkg::pix_t feed,
  output sof_pkg::pix_t value
);

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= feed;
    end
  end

endmodule

// File: hw/rtl/sof_eval.sv
module sof_eval (
  input  sof_pkg::window_t window,
  input  sof_pkg::mask_t   mask,
  input  sof_pkg::pix_t    transparent_code,
  input  sof_pkg::pix_t    outline_code,
  output sof_pkg::pix_t    pixel
);

  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic       any_solid;

  assign row_ok = {mask.bot_ok, 1'b1, mask.top_ok};
  assign col_ok = {mask.right_ok, 1'b1, mask.left_ok};

  always_comb begin
    any_solid = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c] && window[r][c] != transparent_code &&
            window[r][c] != outline_code) begin
          any_solid = 1'b1;
        end
      end
    end
    pixel = (window[1][1] == transparent_code && any_solid) ? outline_code : window[1][1];
  end

endmodule

// File: hw/rtl/sof_out_queue.sv
module sof_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_a,
  input  logic               push_b,
  input  sof_pkg::result_t   entry_a,
  input  sof_pkg::result_t   entry_b,
  output logic               room,
  sof_result_if.source       result
);

  sof_pkg::result_t                  entries [sof_pkg::QUEUE_DEPTH];
  logic [sof_pkg::PTR_W-1:0]         wr_ptr;
  logic [sof_pkg::PTR_W-1:0]         rd_ptr;
  logic [sof_pkg::COUNT_W-1:0]       count;
  logic [sof_pkg::COUNT_W-1:0]       count_next;
  logic [1:0]                        push_n;
  logic                              pop;
  sof_pkg::result_t                  first;
  sof_pkg::result_t                  head;

  assign push_n = {1'b0, push_a} + {1'b0, push_b};
  assign first  = push_a ? entry_a : entry_b;
  assign pop    = result.valid && result.ready;

  assign count_next = count + sof_pkg::COUNT_W'(push_n) - sof_pkg::COUNT_W'(pop);

  // A step pushes up to two results in the cycle after it, so keep two slots in hand.
  assign room = (count + sof_pkg::COUNT_W'(push_n)) <=
                sof_pkg::COUNT_W'(sof_pkg::QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_a || push_b) begin
      entries[wr_ptr] <= first;
    end
    if (push_a && push_b) begin
      entries[wr_ptr + sof_pkg::PTR_W'(1)] <= entry_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sof_pkg::PTR_W'(push_n);
      rd_ptr <= rd_ptr + sof_pkg::PTR_W'(pop);
      count  <= count_next;
    end
  end

  assign head             = entries[rd_ptr];
  assign result.valid     = count != '0;
  assign result.out_index = head.out_index;
  assign result.run_last  = head.run_last;
  assign result.frame_end = head.frame_end;

endmodule

// File: hw/rtl/silhouette_outline_filter.sv
// Outline filter for square SIDE x SIDE sprites of 3-bit palette indices, streamed in
// raster order. It takes one pixel per cycle while the queue has room and no drain runs,
// and gives one result per cycle while the output side is ready; each result trails the
// input by a row, or by a row and a pixel. The pixel stream shifts through a chain of 2*SIDE
// pixel cells whose taps give the two rows above, and a 3x3 window of cells feeds two outline
// evaluators, so the last column of a row yields two results in one step; an eight-entry
// output queue absorbs that and keeps the input at full rate while the output side is
// ready. The last pixel of a frame drains the final row: the chain runs on its own and the
// pixel channel is not ready. The user must write codes through the register port only
// between items, never during a drain; the block itself does not enforce this.
module silhouette_outline_filter (
  input  logic                                clk,
  input  logic                                rst,
  sof_pixel_if.sink                           pixel,
  sof_result_if.source                        result,
  input  logic                                write_enable,
  input  logic [sof_pkg::CFG_INDEX_W-1:0]     write_index,
  input  logic [sof_pkg::CFG_DATA_W-1:0]      write_data
);

  typedef struct packed {
    logic emit_a;
    logic emit_b;
    logic left_ok;
    logic top_ok;
    logic bot_ok;
    logic a_last;
    logic b_last;
    logic b_end;
  } step_t;

  sof_pkg::pix_t               transparent_code;
  sof_pkg::pix_t               outline_code;
  logic [sof_pkg::POS_W-1:0]   column_count;
  logic [sof_pkg::POS_W-1:0]   row_count;
  logic [sof_pkg::POS_W-1:0]   flush_col;
  logic                        flushing;
  logic                        room;
  logic                        accept;
  logic                        step;
  logic [sof_pkg::POS_W-1:0]   c_cur;
  logic [sof_pkg::POS_W-1:0]   r_cur;
  logic [sof_pkg::POS_W-1:0]   pos;
  logic                        col_last;
  logic                        row_last;
  logic                        final_item;
  logic                        has_mid;
  step_t                       flags;
  step_t                       ev;
  logic                        ev_valid;
  sof_pkg::pix_t               chain [sof_pkg::CHAIN_LEN];
  sof_pkg::pix_t               win [3][3];
  sof_pkg::pix_t               new_col [3];
  sof_pkg::window_t            window_a;
  sof_pkg::window_t            window_b;
  sof_pkg::mask_t              mask_a;
  sof_pkg::mask_t              mask_b;
  sof_pkg::pix_t               pix_a;
  sof_pkg::pix_t               pix_b;
  sof_pkg::result_t            entry_a;
  sof_pkg::result_t            entry_b;

  localparam logic [sof_pkg::POS_W-1:0] LAST_POS = sof_pkg::POS_W'(sof_pkg::SIDE - 1);

  // Register port.
  always_ff @(posedge clk) begin
    if (rst) begin
      transparent_code <= sof_pkg::TRANSPARENT_RESET;
      outline_code     <= sof_pkg::OUTLINE_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        sof_pkg::REG_TRANSPARENT: transparent_code <= write_data;
        sof_pkg::REG_OUTLINE:     outline_code     <= write_data;
        default: begin
        end
      endcase
    end
  end

  assign pixel.ready = !flushing && room;
  assign accept      = pixel.valid && pixel.ready;
  assign step        = accept || (flushing && room);

  assign c_cur      = pixel.frame_start ? '0 : column_count;
  assign r_cur      = pixel.frame_start ? '0 : row_count;
  assign col_last   = c_cur == LAST_POS;
  assign row_last   = r_cur == LAST_POS;
  assign final_item = accept && col_last && row_last;

  // During a drain the chain walks the last row, with no row below it.
  assign pos     = flushing ? flush_col : c_cur;
  assign has_mid = flushing || r_cur != '0;

  always_comb begin
    flags.emit_a  = has_mid && pos != '0;
    flags.emit_b  = has_mid && pos == LAST_POS;
    flags.left_ok = pos != sof_pkg::POS_W'(1);
    flags.top_ok  = flushing || r_cur >= sof_pkg::POS_W'(2);
    flags.bot_ok  = !flushing;
    flags.a_last  = flags.emit_a && !flags.emit_b && !flushing;
    flags.b_last  = flags.emit_b && !final_item;
    flags.b_end   = flushing && pos == LAST_POS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      flush_col    <= '0;
      flushing     <= 1'b0;
      ev_valid     <= 1'b0;
    end else begin
      ev_valid <= step;
      if (accept) begin
        column_count <= col_last ? '0 : c_cur + sof_pkg::POS_W'(1);
        if (col_last) begin
          row_count <= row_last ? '0 : r_cur + sof_pkg::POS_W'(1);
        end else begin
          row_count <= r_cur;
        end
        if (final_item) begin
          flushing  <= 1'b1;
          flush_col <= '0;
        end
      end else if (flushing && room) begin
        flush_col <= flush_col + sof_pkg::POS_W'(1);
        if (flush_col == LAST_POS) begin
          flushing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ev <= flags;
  end

  // Line delay: tap SIDE-1 is the row above, the far end two rows above.
  for (genvar k = 0; k < sof_pkg::CHAIN_LEN; k++) begin : g_chain
    if (k == 0) begin : g_head
      sof_cell u_cell (.clk(clk), .shift(step), .feed(pixel.pixel_index), .value(chain[k]));
    end else begin : g_body
      sof_cell u_cell (.clk(clk), .shift(step), .feed(chain[k-1]), .value(chain[k]));
    end
  end

  assign new_col[0] = chain[sof_pkg::CHAIN_LEN-1];
  assign new_col[1] = chain[sof_pkg::SIDE-1];
  assign new_col[2] = pixel.pixel_index;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      if (c == 2) begin : g_edge
        sof_cell u_cell (.clk(clk), .shift(step), .feed(new_col[r]), .value(win[r][c]));
      end else begin : g_inner
        sof_cell u_cell (.clk(clk), .shift(step), .feed(win[r][c+1]), .value(win[r][c]));
      end
    end
  end

  // Evaluator A is centered on the middle column, B on the newest one with no right side.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_a[r][0] = win[r][0];
      window_a[r][1] = win[r][1];
      window_a[r][2] = win[r][2];
      window_b[r][0] = win[r][1];
      window_b[r][1] = win[r][2];
      window_b[r][2] = win[r][2];
    end
  end

  assign mask_a = '{top_ok: ev.top_ok, bot_ok: ev.bot_ok, left_ok: ev.left_ok, right_ok: 1'b1};
  assign mask_b = '{top_ok: ev.top_ok, bot_ok: ev.bot_ok, left_ok: 1'b1, right_ok: 1'b0};

  sof_eval u_eval_a (
    .window(window_a), .mask(mask_a), .transparent_code(transparent_code),
    .outline_code(outline_code), .pixel(pix_a)
  );

  sof_eval u_eval_b (
    .window(window_b), .mask(mask_b), .transparent_code(transparent_code),
    .outline_code(outline_code), .pixel(pix_b)
  );

  assign entry_a = '{out_index: pix_a, run_last: ev.a_last, frame_end: 1'b0};
  assign entry_b = '{out_index: pix_b, run_last: ev.b_last, frame_end: ev.b_end};

  sof_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_a(ev_valid && ev.emit_a),
    .push_b(ev_valid && ev.emit_b),
    .entry_a(entry_a),
    .entry_b(entry_b),
    .room(room),
    .result(result)
  );

`ifndef SYNTHESIS
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !pixel.ready)
    else $error("pixel channel ready while the last row drains");

  a_drain_follows_last: assert property (@(posedge clk) disable iff (rst)
    final_item |=> flushing)
    else $error("last pixel of a frame did not start the drain");

  a_b_needs_a: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev.emit_b |-> ev.emit_a)
    else $error("edge result without the column result before it");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_end |-> result.run_last)
    else $error("frame end beat not marked as the last of its pixel");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef sof_pkg::pix_t line_t [sof_pkg::SIDE];

  typedef struct packed {
    sof_pkg::pix_t pix;
    logic          fs;
  } sprite_pixel_t;

  logic clk;
  logic rst;
  logic write_enable;
  logic [sof_pkg::CFG_INDEX_W-1:0] write_index;
  logic [sof_pkg::CFG_DATA_W-1:0] write_data;

  sof_pixel_if pix_if ();
  sof_result_if res_if ();

  silhouette_outline_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pix_if),
    .result       (res_if),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  // Shadow copy of the filter: line stores, position and the two codes.
  line_t older_line;
  line_t newer_line;
  line_t incoming_line;
  int col_pos;
  int row_pos;
  sof_pkg::pix_t key_clear;
  sof_pkg::pix_t key_outline;

  sprite_pixel_t sprite_feed[$];
  sof_pkg::result_t outlined_queue[$];

  int beats_in;
  int beats_out;
  int flushes;
  int mismatches;
  int burst_left;
  int gap_left;
  int rx_mode;
  int rx_left;
  logic hold_rx;
  logic rx_next;
  sof_pkg::result_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic sof_pkg::pix_t outline_at(input line_t above, input line_t mid,
                                               input line_t below, input bit use_above,
                                               input bit use_below, input int x);
    sof_pkg::pix_t v;
    int nx;
    if (mid[x] != key_clear) return mid[x];
    for (int dy = 0; dy < 3; dy++) begin
      if ((dy == 0 && !use_above) || (dy == 2 && !use_below)) continue;
      for (int dx = -1; dx <= 1; dx++) begin
        nx = x + dx;
        if (nx < 0 || nx >= sof_pkg::SIDE) continue;
        v = (dy == 0) ? above[nx] : (dy == 1) ? mid[nx] : below[nx];
        if (v != key_clear && v != key_outline) return key_outline;
      end
    end
    return mid[x];
  endfunction

  function automatic sof_pkg::result_t make_result(input sof_pkg::pix_t idx);
    sof_pkg::result_t r;
    r.out_index = idx;
    r.run_last  = 1'b0;
    r.frame_end = 1'b0;
    return r;
  endfunction

  // Works out the outlined pixels that one accepted pixel beat releases.
  task automatic outline_step(input sof_pkg::pix_t p, input logic fs);
    sof_pkg::result_t batch[$];
    bit last_of_frame;
    last_of_frame = 1'b0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    incoming_line[col_pos] = p;
    if (row_pos >= 1) begin
      if (col_pos >= 1)
        batch.push_back(make_result(outline_at(older_line, newer_line, incoming_line,
                                               row_pos >= 2, 1'b1, col_pos - 1)));
      if (col_pos == sof_pkg::SIDE - 1)
        batch.push_back(make_result(outline_at(older_line, newer_line, incoming_line,
                                               row_pos >= 2, 1'b1, col_pos)));
      if (row_pos == sof_pkg::SIDE - 1 && col_pos == sof_pkg::SIDE - 1) begin
        // The bottom row has no row below it.
        for (int x = 0; x < sof_pkg::SIDE; x++)
          batch.push_back(make_result(outline_at(newer_line, incoming_line, incoming_line,
                                                 1'b1, 1'b0, x)));
        last_of_frame = 1'b1;
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].run_last = 1'b1;
      batch[batch.size() - 1].frame_end = last_of_frame;
    end
    foreach (batch[k]) outlined_queue.push_back(batch[k]);
    if (col_pos == sof_pkg::SIDE - 1) begin
      older_line = newer_line;
      newer_line = incoming_line;
      col_pos = 0;
      row_pos = (row_pos == sof_pkg::SIDE - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic sof_pkg::pix_t pick_pixel(input int solid_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 100 - solid_pct) return key_clear;
    if (roll < 100 - solid_pct + 8) return key_outline;
    return sof_pkg::pix_t'($urandom_range(0, 7));
  endfunction

  // Queues len pixels; noisy frames get a stray frame start now and then.
  task automatic queue_frame(input int len, input bit first_start, input bit noisy);
    sprite_pixel_t item;
    int density;
    density = $urandom_range(5, 90);
    for (int k = 0; k < len; k++) begin
      item.pix = pick_pixel(density);
      item.fs  = (k == 0) ? first_start : (noisy && $urandom_range(0, 199) == 0);
      sprite_feed.push_back(item);
    end
  endtask

  // Waits until the block has nothing in flight; a row-0 pixel or a drain
  // can still be at work after the last result, so wait on past it.
  task automatic settle();
    while (sprite_feed.size() > 0 || pix_if.valid || outlined_queue.size() > 0)
      @(negedge clk);
    repeat (sof_pkg::SIDE + 16) @(negedge clk);
  endtask

  task automatic write_codes(input sof_pkg::pix_t clear_c, input sof_pkg::pix_t outline_c);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= sof_pkg::REG_TRANSPARENT;
    write_data   <= clear_c;
    @(posedge clk);
    write_index  <= sof_pkg::REG_OUTLINE;
    write_data   <= outline_c;
    @(posedge clk);
    write_enable <= 1'b0;
    key_clear   = clear_c;
    key_outline = outline_c;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid       <= 1'b0;
      pix_if.pixel_index <= '0;
      pix_if.frame_start <= 1'b0;
      burst_left = $urandom_range(1, 64);
      gap_left   = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        outline_step(pix_if.pixel_index, pix_if.frame_start);
        sprite_feed.pop_front();
        beats_in++;
      end
      if (!(pix_if.valid && !pix_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_if.valid <= 1'b0;
        end else if (sprite_feed.size() > 0) begin
          pix_if.valid       <= 1'b1;
          pix_if.pixel_index <= sprite_feed[0].pix;
          pix_if.frame_start <= sprite_feed[0].fs;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 64);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between modes at random intervals.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_mode = 0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        2: rx_next = $urandom_range(0, 1);
        3: rx_next = ($urandom_range(0, 3) == 0);
        default: rx_next = 1'b1;
      endcase
      res_if.ready <= rx_next && !hold_rx;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      beats_out++;
      if (res_if.frame_end) flushes++;
      if (outlined_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d arrived with none expected: index %0d last %0b end %0b",
                   beats_out, res_if.out_index, res_if.run_last, res_if.frame_end);
      end else begin
        want = outlined_queue.pop_front();
        if (want.out_index !== res_if.out_index || want.run_last !== res_if.run_last ||
            want.frame_end !== res_if.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d: expected index %0d last %0b end %0b, got %0d %0b %0b",
                     beats_out, want.out_index, want.run_last, want.frame_end,
                     res_if.out_index, res_if.run_last, res_if.frame_end);
        end
      end
    end
  end

  // Long output hold-offs while the sender keeps going, so the block backs up.
  initial begin
    hold_rx = 1'b0;
    while (beats_in < 40) @(negedge clk);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
    while (beats_in < 200) @(negedge clk);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (200) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    sof_pkg::pix_t directed_pix [18];
    sprite_pixel_t item;
    directed_pix = '{3'd7, 3'd0, 3'd0, 3'd7, 3'd2, 3'd0, 3'd1, 3'd3, 3'd4,
                     3'd5, 3'd6, 3'd7, 3'd0, 3'd7, 3'd0, 3'd2, 3'd7, 3'd0};
    rst          = 1'b1;
    write_enable = 1'b0;
    write_index  = '0;
    write_data   = '0;
    key_clear   = sof_pkg::TRANSPARENT_RESET;
    key_outline = sof_pkg::OUTLINE_RESET;
    col_pos = 0;
    row_pos = 0;
    beats_in   = 0;
    beats_out  = 0;
    flushes    = 0;
    mismatches = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset codes. Short directed run: extreme indices and a restart mid-row.
    foreach (directed_pix[k]) begin
      item.pix = directed_pix[k];
      item.fs  = (k == 0 || k == 12);
      sprite_feed.push_back(item);
    end
    queue_frame($urandom_range(2 * sof_pkg::SIDE + 2, 2 * sof_pkg::SIDE + sof_pkg::SIDE / 2),
                1'b1, 1'b1);
    queue_frame($urandom_range(sof_pkg::SIDE + 2, sof_pkg::SIDE + sof_pkg::SIDE / 2),
                1'b1, 1'b0);
    settle();

    // Codes at opposite extremes, written mid-frame; the pixels that follow
    // carry on from the current position without a frame start.
    write_codes(3'd7, 3'd0);
    queue_frame($urandom_range(sof_pkg::SIDE + 2, sof_pkg::SIDE + sof_pkg::SIDE / 2),
                1'b0, 1'b0);
    settle();

    // Equal codes: anything other than that code counts as solid.
    write_codes(3'd5, 3'd5);
    queue_frame($urandom_range(sof_pkg::SIDE + 2, sof_pkg::SIDE + sof_pkg::SIDE / 2),
                1'b1, 1'b1);
    settle();

    write_codes(3'd0, 3'd7);
    queue_frame($urandom_range(sof_pkg::SIDE + 2, sof_pkg::SIDE + sof_pkg::SIDE / 2),
                1'b0, 1'b1);

    while (sprite_feed.size() > 0 || pix_if.valid) @(negedge clk);
    for (int k = 0; k < 20000 && outlined_queue.size() > 0; k++) @(negedge clk);
    repeat (sof_pkg::SIDE + 16) @(negedge clk);

    if (outlined_queue.size() > 0)
      $display("%0d expected result beats never arrived", outlined_queue.size());
    $display("Run covered %0d pixel beats and %0d result beats with %0d frame flushes,", beats_in,
             beats_out, flushes);
    $display("under four code settings including equal codes and long output stalls.");
    if (mismatches == 0 && outlined_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sof_pkg.sv
hw/rtl/sof_if.sv
hw/rtl/sof_cell.sv
hw/rtl/sof_eval.sv
hw/rtl/sof_out_queue.sv
hw/rtl/silhouette_outline_filter.sv
tb/sv/tb_top.sv
